[hw/rtl/vn3_pkg.sv]
// Shared types and constants for the 3D vector normaliser.
package vn3_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int COMP_W        = 32;
    localparam int SUM_W         = 64;
    localparam int ROOT_W        = 32;
    localparam int LEN_W         = 33;
    localparam int CFG_W         = 16;
    localparam logic [CFG_W-1:0] MIN_LENGTH_RST = 16'd1;

    typedef struct packed {
        logic signed [COMP_W-1:0] comp_x;
        logic signed [COMP_W-1:0] comp_y;
        logic signed [COMP_W-1:0] comp_z;
    } t_vec_in;

    typedef struct packed {
        logic signed [COMP_W-1:0] unit_x;
        logic signed [COMP_W-1:0] unit_y;
        logic signed [COMP_W-1:0] unit_z;
        logic [LEN_W-1:0]         length;
        logic                     was_scaled;
        logic                     is_zero_length;
    } t_vec_out;

    // Data that travels alongside the arithmetic down the row of cells.
    typedef struct packed {
        t_vec_in                      vec;
        logic [2:0][COMP_W-1:0]       mag;
        logic [2:0]                   neg;
        logic                         zero;
        logic [ROOT_W-1:0]            len;
        logic                         scaled;
    } t_side;

endpackage

[hw/rtl/vn3_sqrt_cell.sv]
// One digit of the restoring square root: takes two bits of the radicand.
module vn3_sqrt_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  vn3_pkg::t_side        i_side,
    input  logic [63:0]           i_rad,
    input  logic [32:0]           i_rem,
    input  logic [31:0]           i_root,
    output logic                  o_valid,
    output vn3_pkg::t_side        o_side,
    output logic [63:0]           o_rad,
    output logic [32:0]           o_rem,
    output logic [31:0]           o_root
);
    import vn3_pkg::*;

    logic [34:0] n_trial_rem;
    logic [34:0] n_trial;
    logic        n_take;

    assign n_trial_rem = {i_rem, i_rad[63:62]};
    assign n_trial     = {1'b0, i_root, 2'b01};
    assign n_take      = (n_trial_rem >= n_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_side <= i_side;
            o_rad  <= {i_rad[61:0], 2'b00};
            if (n_take) begin
                o_rem  <= 33'(n_trial_rem - n_trial);
                o_root <= {i_root[30:0], 1'b1};
            end else begin
                o_rem  <= n_trial_rem[32:0];
                o_root <= {i_root[30:0], 1'b0};
            end
        end
    end

endmodule

[hw/rtl/vn3_div_cell.sv]
// One quotient bit of the restoring division, three lanes side by side.
module vn3_div_cell #(
    parameter int QW   = vn3_pkg::FRAC_BITS_DEF + 1,
    parameter int STEP = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  vn3_pkg::t_side        i_side,
    input  logic [2:0][32:0]      i_rem,
    input  logic [2:0][QW-1:0]    i_quo,
    output logic                  o_valid,
    output vn3_pkg::t_side        o_side,
    output logic [2:0][32:0]      o_rem,
    output logic [2:0][QW-1:0]    o_quo
);
    import vn3_pkg::*;

    logic [2:0][33:0] n_part;
    logic [2:0]       n_take;
    logic [33:0]      n_div;

    assign n_div = {2'b00, i_side.len};

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            // Only the first step brings in a dividend bit; the rest are zeros.
            n_part[l] = {i_rem[l], (STEP == 0) ? i_side.mag[l][0] : 1'b0};
            n_take[l] = (n_part[l] >= n_div);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_side <= i_side;
            for (int l = 0; l < 3; l++) begin
                o_rem[l] <= n_take[l] ? 33'(n_part[l] - n_div) : n_part[l][32:0];
                o_quo[l] <= {i_quo[l][QW-2:0], n_take[l]};
            end
        end
    end

endmodule

[hw/rtl/vector3d_normalize_top.sv]
// Top level of the 3D vector normaliser: squares, root cell row, divider cell row.
// Stages from input transaction to result, in order:
//   3 for magnitude, square and sum, 32 root cells, FRAC_BITS+1 divider cells, 1 output.
// Throughput: one transaction per cycle unless stalled; every cell hands its item on as the row advances.
// The whole row holds when a finished result is stalled at the output register.
// Reset clears all valid bits and sets min_length to 1; payload is not reset.
module vector3d_normalize_top #(
    parameter int FRAC_BITS = vn3_pkg::FRAC_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  vn3_pkg::t_vec_in        i_in_data,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output vn3_pkg::t_vec_out       o_out_data,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [vn3_pkg::CFG_W-1:0] i_cfg_data
);
    import vn3_pkg::*;

    localparam int QW   = FRAC_BITS + 1;
    localparam int NSQ  = ROOT_W;
    localparam int NDIV = QW;

    logic             w_adv;
    logic [CFG_W-1:0] r_min_len;

    // Advance the whole row unless the output register holds an untaken result.
    assign w_adv       = !(o_out_valid && i_out_stall);
    assign o_in_stall  = !w_adv;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_len <= MIN_LENGTH_RST;
        end else if (i_cfg_valid) begin
            r_min_len <= i_cfg_data;
        end
    end

    // Front end: magnitudes and the zero-length test.
    t_side            n_side0;
    logic [2:0][COMP_W-1:0] n_raw;

    always_comb begin
        n_raw = {i_in_data.comp_x, i_in_data.comp_y, i_in_data.comp_z};
        n_side0 = '0;
        n_side0.vec  = i_in_data;
        n_side0.zero = 1'b1;
        for (int l = 0; l < 3; l++) begin
            n_side0.neg[l] = n_raw[2-l][COMP_W-1];
            n_side0.mag[l] = n_raw[2-l][COMP_W-1] ? (~n_raw[2-l] + 32'd1) : n_raw[2-l];
            if (n_side0.mag[l] > {16'd0, r_min_len}) begin
                n_side0.zero = 1'b0;
            end
        end
    end

    logic             r_v1, r_v2, r_v3;
    t_side            r_side1, r_side2, r_side3;
    logic [2:0][SUM_W-1:0] r_sq;
    logic [SUM_W-1:0] r_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= i_in_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_side1 <= n_side0;
            r_side2 <= r_side1;
            for (int l = 0; l < 3; l++) begin
                r_sq[l] <= r_side1.mag[l] * r_side1.mag[l];
            end
            r_side3 <= r_side2;
            r_sum   <= r_sq[0] + r_sq[1] + r_sq[2];
        end
    end

    // Root cell row.
    logic  [NSQ:0]          w_sv;
    t_side                  w_ss   [0:NSQ];
    logic  [63:0]           w_rad  [0:NSQ];
    logic  [32:0]           w_srem [0:NSQ];
    logic  [31:0]           w_root [0:NSQ];

    assign w_sv[0]   = r_v3;
    assign w_ss[0]   = r_side3;
    assign w_rad[0]  = r_sum;
    assign w_srem[0] = '0;
    assign w_root[0] = '0;

    for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
        vn3_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_valid (w_sv[k]),
            .i_side  (w_ss[k]),
            .i_rad   (w_rad[k]),
            .i_rem   (w_srem[k]),
            .i_root  (w_root[k]),
            .o_valid (w_sv[k+1]),
            .o_side  (w_ss[k+1]),
            .o_rad   (w_rad[k+1]),
            .o_rem   (w_srem[k+1]),
            .o_root  (w_root[k+1])
        );
    end

    // Divider cell row; start each lane with the dividend's upper bits.
    logic  [NDIV:0]         w_dv;
    t_side                  w_ds   [0:NDIV];
    logic  [2:0][32:0]      w_drem [0:NDIV];
    logic  [2:0][QW-1:0]    w_quo  [0:NDIV];
    t_side                  w_ds0;
    logic  [2:0][32:0]      w_drem0;

    always_comb begin
        w_ds0        = w_ss[NSQ];
        w_ds0.len    = w_root[NSQ];
        w_ds0.scaled = (w_root[NSQ] > {16'd0, r_min_len});
        for (int l = 0; l < 3; l++) begin
            w_drem0[l] = {2'b00, w_ss[NSQ].mag[l][COMP_W-1:1]};
        end
    end

    assign w_ds[0]   = w_ds0;
    assign w_drem[0] = w_drem0;
    assign w_dv[0]   = w_sv[NSQ];
    assign w_quo[0]  = '0;

    for (genvar k = 0; k < NDIV; k++) begin : g_div
        vn3_div_cell #(
            .QW   (QW),
            .STEP (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_valid (w_dv[k]),
            .i_side  (w_ds[k]),
            .i_rem   (w_drem[k]),
            .i_quo   (w_quo[k]),
            .o_valid (w_dv[k+1]),
            .o_side  (w_ds[k+1]),
            .o_rem   (w_drem[k+1]),
            .o_quo   (w_quo[k+1])
        );
    end

    // Output register: apply signs or pass the input through.
    t_side                  w_fs;
    logic [2:0][COMP_W-1:0] n_unit;
    logic [2:0][COMP_W-1:0] n_q32;
    t_vec_out               n_out;

    assign w_fs = w_ds[NDIV];

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            n_q32[l]  = COMP_W'(w_quo[NDIV][l]);
            n_unit[l] = w_fs.neg[l] ? (~n_q32[l] + 32'd1) : n_q32[l];
        end
        n_out.unit_x         = w_fs.scaled ? n_unit[0] : w_fs.vec.comp_x;
        n_out.unit_y         = w_fs.scaled ? n_unit[1] : w_fs.vec.comp_y;
        n_out.unit_z         = w_fs.scaled ? n_unit[2] : w_fs.vec.comp_z;
        n_out.length         = {1'b0, w_fs.len};
        n_out.was_scaled     = w_fs.scaled;
        n_out.is_zero_length = w_fs.zero;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (w_adv) begin
            o_out_valid <= w_dv[NDIV];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            o_out_data <= n_out;
        end
    end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the 3D vector normaliser top level.
module tb_top;
    import vn3_pkg::*;

    localparam int FB      = 16;
    localparam int LAT     = FB + 37;
    localparam int N_RAND  = 1900;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    t_vec_in          in_data = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    t_vec_out         out_data;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data = '0;

    vector3d_normalize_top #(.FRAC_BITS(FB)) dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_data(out_data),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    // Predictor copy of the threshold register
    logic [CFG_W-1:0] thresh = MIN_LENGTH_RST;

    t_vec_in  vec_pending[$];
    t_vec_out norm_expected[$];

    int n_mismatch = 0;
    int n_checked  = 0;
    int n_scaled   = 0;
    int n_zero     = 0;
    int send_idle  = 0;   // percent idle on the sending side
    int recv_stall = 0;   // percent stall on the receiving side
    int hold_off   = 0;   // cycles of forced long stall still to run

    // Floor square root of a 64-bit sum, bit by bit
    function automatic logic [63:0] floor_sqrt(logic [63:0] n);
        logic [63:0] root, b;
        root = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= root + b) begin
                n = n - (root + b);
                root = (root >> 1) + b;
            end else begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        return root;
    endfunction

    function automatic t_vec_out normalise(t_vec_in v, logic [CFG_W-1:0] th);
        t_vec_out r;
        logic [31:0] c[3];
        logic [63:0] mag[3];
        logic        neg[3];
        logic [63:0] sum, len, q;
        logic [31:0] res[3];
        logic        zero;
        c[0] = v.comp_x; c[1] = v.comp_y; c[2] = v.comp_z;
        sum = 0;
        zero = 1'b1;
        for (int i = 0; i < 3; i++) begin
            neg[i] = c[i][31];
            mag[i] = neg[i] ? (64'h1_0000_0000 - {32'd0, c[i]}) : {32'd0, c[i]};
            sum += mag[i] * mag[i];
            if (mag[i] > th) zero = 1'b0;
        end
        len = floor_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
            if (len > th) begin
                q = (mag[i] << FB) / len;
                res[i] = neg[i] ? 32'(64'h1_0000_0000 - q) : q[31:0];
            end else begin
                res[i] = c[i];
            end
        end
        r.unit_x = res[0]; r.unit_y = res[1]; r.unit_z = res[2];
        r.length = len[LEN_W-1:0];
        r.was_scaled = (len > th);
        r.is_zero_length = zero;
        return r;
    endfunction

    // Acceptance is sampled at the rising edge, the drive happens at the falling edge
    logic in_taken = 1'b0;
    always @(posedge clk) begin
        in_taken   <= in_valid && !in_stall && rst_n;
        if (in_valid && !in_stall && rst_n)
            norm_expected.push_back(normalise(in_data, thresh));
        if (cfg_valid && cfg_ready && rst_n)
            thresh <= cfg_data;
    end

    // Driver: offer the next queued vector, hold it while stalled
    always @(negedge clk) begin
        if (rst_n) begin
            if (!in_valid || in_taken) begin
                if (vec_pending.size() > 0 && $urandom_range(99) >= send_idle) begin
                    in_data  <= vec_pending.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: long hold-off first, otherwise random stalls
    always @(negedge clk) begin
        if (rst_n) begin
            if (hold_off > 0) begin
                out_stall <= 1'b1;
                hold_off  <= hold_off - 1;
            end else begin
                out_stall <= ($urandom_range(99) < recv_stall);
            end
        end
    end

    // Monitor: compare each result transaction with the oldest expectation
    always @(posedge clk) begin
        t_vec_out e;
        if (rst_n && out_valid && !out_stall) begin
            if (norm_expected.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected result %h", out_data);
            end else begin
                e = norm_expected.pop_front();
                n_checked++;
                if (e.was_scaled) n_scaled++;
                if (e.is_zero_length) n_zero++;
                if (out_data.unit_x !== e.unit_x || out_data.unit_y !== e.unit_y ||
                    out_data.unit_z !== e.unit_z || out_data.length !== e.length ||
                    out_data.was_scaled !== e.was_scaled ||
                    out_data.is_zero_length !== e.is_zero_length) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display({"mismatch: exp %h %h %h len %h s%b z%b",
                                  " / got %h %h %h len %h s%b z%b"},
                            e.unit_x, e.unit_y, e.unit_z, e.length, e.was_scaled,
                            e.is_zero_length, out_data.unit_x, out_data.unit_y,
                            out_data.unit_z, out_data.length, out_data.was_scaled,
                            out_data.is_zero_length);
                end
            end
        end
    end

    function automatic logic [31:0] rand_comp();
        case ($urandom_range(5))
            0: return $urandom_range(8) - 4;          // near zero
            1: return $urandom_range(131071) - 65536; // around the threshold scale
            2: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
            3: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic push_vec(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        t_vec_in v;
        v.comp_x = x; v.comp_y = y; v.comp_z = z;
        vec_pending.push_back(v);
    endtask

    task automatic drain();
        while (vec_pending.size() > 0 || in_valid || norm_expected.size() > 0)
            @(posedge clk);
        repeat (LAT + 5) @(posedge clk);
    endtask

    task automatic write_thresh(logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(int n, int idle, int stall);
        send_idle  = idle;
        recv_stall = stall;
        for (int i = 0; i < n; i++)
            push_vec(rand_comp(), rand_comp(), rand_comp());
        drain();
    endtask

    initial begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: zero vector, extremes, most negative components, threshold edges
        push_vec(0, 0, 0);
        push_vec(1, 0, 0);
        push_vec(2, 0, 0);
        push_vec(32'hFFFF_FFFF, 0, 0);
        push_vec(32'hFFFF_FFFE, 0, 0);
        push_vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        push_vec(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push_vec(32'h8000_0000, 0, 0);
        push_vec(32'h7FFF_FFFF, 32'h8000_0000, 1);
        push_vec(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        push_vec(32'hFFFF_0000, 0, 32'h0001_0000);
        push_vec(1, 1, 1);
        push_vec(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F);
        push_vec(32'hAAAA_AAAA, 32'h5555_5555, 32'hF0F0_F0F0);
        drain();

        // Threshold extremes, directed items at each
        write_thresh(16'hFFFF);
        push_vec(32'h0000_FFFF, 0, 0);
        push_vec(32'h0001_0000, 0, 0);
        push_vec(32'h0000_FFFF, 32'h0000_FFFF, 0);
        push_vec(32'hFFFF_0001, 0, 0);
        drain();
        write_thresh(16'h0000);
        push_vec(0, 0, 0);
        push_vec(1, 0, 0);
        push_vec(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        drain();

        // Random phases across idling patterns and thresholds
        write_thresh(16'd1);
        random_phase(N_RAND / 5, 0, 0);
        write_thresh(16'($urandom));
        random_phase(N_RAND / 5, 75, 0);
        write_thresh(16'hFFFF);
        random_phase(N_RAND / 5, 0, 75);
        write_thresh(16'($urandom_range(300)));
        random_phase(N_RAND / 5, 11, 11);

        // Long receiver hold-off while the sender keeps offering
        write_thresh(16'd0);
        hold_off = 3 * LAT;
        random_phase(N_RAND / 5, 0, 0);

        $display("checked %0d normalised vectors (%0d scaled, %0d zero-length)",
                 n_checked, n_scaled, n_zero);
        $display("covered threshold extremes, all idle mixes and a long output hold-off");
        if (n_mismatch == 0 && norm_expected.size() == 0)
            $display("vector3d_normalize_top regression: pass");
        else
            $display("vector3d_normalize_top regression: fail");
        $finish;
    end

    initial begin
        #8000000;
        $display("vector3d_normalize_top regression: fail");
        $finish;
    end
endmodule
